// ===== src/pressure_profile_setpoint_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Pressure profile setpoint generator assertion macros
// Shared concurrent assertion forms for the setpoint generator.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_PROFILE_SETPOINT_GENERATOR_MACROS_SVH
`define PRESSURE_PROFILE_SETPOINT_GENERATOR_MACROS_SVH

// Same-cycle implication, checked after reset is released.
`define PPSG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppsg check failed");

// Next-cycle implication, checked after reset is released.
`define PPSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppsg check failed");

`endif

// ===== src/ppsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Setpoint generator package
// Shared types, codes and the quarter-wave sine table entry function.
// ----------------------------------------------------------------------------
package ppsg_pkg;

  localparam int MAX_POINTS_DEF = 6;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int DIV_STEPS = 16;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_STATIC = 2'd1;
  localparam logic [1:0] MODE_SINE   = 2'd2;
  localparam logic [1:0] MODE_CUSTOM = 2'd3;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_DURATION = 3'd1;
  localparam logic [2:0] REG_COUNT    = 3'd2;
  localparam logic [2:0] REG_STATIC   = 3'd3;
  localparam logic [2:0] REG_AMP      = 3'd4;
  localparam logic [2:0] REG_STEP     = 3'd5;
  localparam logic [2:0] REG_OFFSET   = 3'd6;

  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SMUL1,
    S_SROM,
    S_SMUL2,
    S_SFIN,
    S_SCAN,
    S_CSEL,
    S_CMUL,
    S_DIVI,
    S_DIV,
    S_CFIN,
    S_OUT
  } state_t;

  function automatic logic [14:0] rom_entry(int unsigned j, int unsigned tb);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    u  = 64'(j) << (30 - tb);
    u2 = (u * u) >> 30;
    t  = C9;
    t  = C7 - ((t * u2) >> 30);
    t  = C5 - ((t * u2) >> 30);
    t  = C3 - ((t * u2) >> 30);
    t  = C1 - ((t * u2) >> 30);
    s  = (t * u) >> 30;
    r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

// ===== src/pressure_profile_setpoint_generator.sv =====
// ----------------------------------------------------------------------------
// Pressure profile setpoint generator
// Timed static, sine or breakpoint pressure target with a finished flag.
// ----------------------------------------------------------------------------
// Start, load and unused items go from idle straight to the output state.
// A tick passes a check; sine adds multiply, table read and multiply, and
// breakpoints read one point per cycle, then do a 16-step serial divide.
// One item is in work at a time; a shared 33x33 multiplier serves the sine
// and breakpoint paths. Reset (rst_n low, synchronous) clears configuration
// registers, breakpoints and start time to zero and sets the finished flag.
module pressure_profile_setpoint_generator #(
  parameter int MAX_POINTS      = ppsg_pkg::MAX_POINTS_DEF,
  parameter int SINE_TABLE_BITS = ppsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // time_now[31:0], point_index[34:32], point_time[66:35],
  // point_pressure[82:67], zero fill above.
  input  logic [87:0] in_tdata,
  // cmd[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // target[15:0].
  output logic [15:0] out_tdata,
  // finished[0].
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "pressure_profile_setpoint_generator_macros.svh"

  localparam int Mpw = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int Tb  = SINE_TABLE_BITS;

  ppsg_pkg::state_t state_r, state_nxt;

  logic [1:0]         mode_r;
  logic [31:0]        duration_r;
  logic [2:0]         count_r;
  logic signed [15:0] static_r;
  logic signed [15:0] amp_r;
  logic [31:0]        step_r;
  logic signed [15:0] offset_r;

  logic [31:0]        start_time_r;
  logic               done_r;
  logic [31:0]        bt_r [MAX_POINTS];
  logic signed [15:0] bp_r [MAX_POINTS];

  logic [31:0]        e_r;
  logic [Mpw-1:0]     idx_r;
  logic               bad_r;
  logic               found_r;
  logic [31:0]        first_t_r;
  logic signed [15:0] first_p_r;
  logic [31:0]        prev_t_r;
  logic signed [15:0] prev_p_r;
  logic [31:0]        ta_r;
  logic [31:0]        tb_r;
  logic signed [15:0] pa_r;
  logic signed [15:0] pb_r;
  logic               dneg_r;
  logic [31:0]        den_r;
  logic [31:0]        rem_r;
  logic [15:0]        quo_r;
  logic [3:0]         cnt_r;
  logic               neg_r;
  logic signed [48:0] prod_r;
  logic signed [15:0] target_r;
  logic               out_valid_r;
  logic signed [15:0] out_target_r;
  logic               out_fin_r;

  logic               in_xfer;
  logic [1:0]         in_cmd;
  logic [31:0]        in_now;
  logic [2:0]         in_pidx;
  logic [31:0]        in_ptime;
  logic signed [15:0] in_ppres;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [Tb:0]        rom_addr;
  logic [14:0]        rom_data;

  logic               count_bad;
  logic               last_idx;
  logic [31:0]        cur_t;
  logic signed [15:0] cur_p;
  logic signed [16:0] dp;
  logic [16:0]        dabs;
  logic [32:0]        shifted;
  logic [32:0]        trial;
  logic signed [48:0] sine_sh;
  logic signed [49:0] sine_sum;
  logic signed [15:0] sine_sat;
  logic signed [17:0] cust_sum;
  logic               out_free;

  assign in_cmd   = in_tuser;
  assign in_now   = in_tdata[31:0];
  assign in_pidx  = in_tdata[34:32];
  assign in_ptime = in_tdata[66:35];
  assign in_ppres = in_tdata[82:67];
  assign in_xfer  = in_tvalid && in_tready;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_target_r;
  assign out_tuser  = out_fin_r;
  assign out_free   = !out_valid_r || out_tready;

  assign count_bad = (count_r == 3'd0) || (32'(count_r) > 32'(MAX_POINTS));
  assign last_idx  = (32'(idx_r) == 32'(count_r) - 32'd1);
  assign cur_t     = bt_r[idx_r];
  assign cur_p     = bp_r[idx_r];
  assign dp        = 17'(pb_r) - 17'(pa_r);
  assign dabs      = dp[16] ? -dp : dp;
  assign shifted   = {rem_r, quo_r[15]};
  assign trial     = shifted - {1'b0, den_r};
  assign mul_p     = mul_a * mul_b;
  assign sine_sh   = (prod_r + 49'sd16384) >>> 15;
  assign sine_sum  = 50'(sine_sh) + 50'(offset_r);
  assign sine_sat  = (sine_sum > 50'sd32767) ? 16'sh7fff :
                     (sine_sum < -50'sd32768) ? 16'sh8000 : sine_sum[15:0];
  assign cust_sum  = 18'(pa_r) + (dneg_r ? -18'(quo_r) : 18'(quo_r));

  ppsg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppsg_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_cmd == ppsg_pkg::CMD_TICK) ? ppsg_pkg::S_CHECK : ppsg_pkg::S_OUT;
        end
      end
      ppsg_pkg::S_CHECK: begin
        if (e_r >= duration_r) begin
          state_nxt = ppsg_pkg::S_OUT;
        end else begin
          unique case (mode_r)
            ppsg_pkg::MODE_SINE:   state_nxt = ppsg_pkg::S_SMUL1;
            ppsg_pkg::MODE_CUSTOM: state_nxt = count_bad ? ppsg_pkg::S_OUT : ppsg_pkg::S_SCAN;
            default:               state_nxt = ppsg_pkg::S_OUT;
          endcase
        end
      end
      ppsg_pkg::S_SMUL1: state_nxt = ppsg_pkg::S_SROM;
      ppsg_pkg::S_SROM:  state_nxt = ppsg_pkg::S_SMUL2;
      ppsg_pkg::S_SMUL2: state_nxt = ppsg_pkg::S_SFIN;
      ppsg_pkg::S_SFIN:  state_nxt = ppsg_pkg::S_OUT;
      ppsg_pkg::S_SCAN: begin
        if (last_idx) begin
          state_nxt = ppsg_pkg::S_CSEL;
        end
      end
      ppsg_pkg::S_CSEL: begin
        if (bad_r || e_r <= first_t_r || e_r >= prev_t_r) begin
          state_nxt = ppsg_pkg::S_OUT;
        end else begin
          state_nxt = ppsg_pkg::S_CMUL;
        end
      end
      ppsg_pkg::S_CMUL: state_nxt = ppsg_pkg::S_DIVI;
      ppsg_pkg::S_DIVI: state_nxt = ppsg_pkg::S_DIV;
      ppsg_pkg::S_DIV: begin
        if (cnt_r == 4'(ppsg_pkg::DIV_STEPS - 1)) begin
          state_nxt = ppsg_pkg::S_CFIN;
        end
      end
      ppsg_pkg::S_CFIN: state_nxt = ppsg_pkg::S_OUT;
      ppsg_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = ppsg_pkg::S_IDLE;
        end
      end
      default: state_nxt = ppsg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ppsg_pkg::S_IDLE);
    mul_a     = {1'b0, e_r};
    mul_b     = {1'b0, step_r};
    if (prod_r[30]) begin
      rom_addr = (Tb+1)'(1 << Tb) - {1'b0, prod_r[29:30-Tb]};
    end else begin
      rom_addr = {1'b0, prod_r[29:30-Tb]};
    end
    unique case (state_r)
      ppsg_pkg::S_SMUL2: begin
        mul_a = 33'(amp_r);
        mul_b = neg_r ? -33'(rom_data) : 33'(rom_data);
      end
      ppsg_pkg::S_CMUL: begin
        mul_a = {1'b0, e_r - ta_r};
        mul_b = 33'(dabs);
      end
      default: begin
        mul_a = {1'b0, e_r};
        mul_b = {1'b0, step_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppsg_pkg::S_IDLE;
      mode_r       <= '0;
      duration_r   <= '0;
      count_r      <= '0;
      static_r     <= '0;
      amp_r        <= '0;
      step_r       <= '0;
      offset_r     <= '0;
      start_time_r <= '0;
      done_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        bt_r[i] <= '0;
        bp_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ppsg_pkg::REG_MODE:     mode_r     <= cfg_data[1:0];
          ppsg_pkg::REG_DURATION: duration_r <= cfg_data;
          ppsg_pkg::REG_COUNT:    count_r    <= cfg_data[2:0];
          ppsg_pkg::REG_STATIC:   static_r   <= cfg_data[15:0];
          ppsg_pkg::REG_AMP:      amp_r      <= cfg_data[15:0];
          ppsg_pkg::REG_STEP:     step_r     <= cfg_data;
          ppsg_pkg::REG_OFFSET:   offset_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        if (in_cmd == ppsg_pkg::CMD_START) begin
          start_time_r <= in_now;
          done_r       <= 1'b0;
        end else if (in_cmd == ppsg_pkg::CMD_LOAD) begin
          if (32'(in_pidx) < 32'(MAX_POINTS)) begin
            bt_r[Mpw'(in_pidx)] <= in_ptime;
            bp_r[Mpw'(in_pidx)] <= in_ppres;
          end
          done_r <= 1'b0;
        end
      end
      if (state_r == ppsg_pkg::S_CHECK && e_r >= duration_r) begin
        done_r <= 1'b1;
      end
      if (state_r == ppsg_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ppsg_pkg::S_SMUL1 || state_r == ppsg_pkg::S_SMUL2 ||
        state_r == ppsg_pkg::S_CMUL) begin
      prod_r <= mul_p[48:0];
    end
    if (state_r == ppsg_pkg::S_OUT && out_free) begin
      out_target_r <= target_r;
      out_fin_r    <= done_r;
    end
    case (state_r)
      ppsg_pkg::S_IDLE: begin
        e_r      <= in_now - start_time_r;
        target_r <= '0;
        idx_r    <= '0;
        bad_r    <= 1'b0;
        found_r  <= 1'b0;
      end
      ppsg_pkg::S_CHECK: begin
        if (e_r < duration_r && mode_r == ppsg_pkg::MODE_STATIC) begin
          target_r <= static_r;
        end
      end
      ppsg_pkg::S_SROM: begin
        neg_r <= prod_r[31];
      end
      ppsg_pkg::S_SFIN: begin
        target_r <= sine_sat;
      end
      ppsg_pkg::S_SCAN: begin
        if (idx_r == '0) begin
          first_t_r <= cur_t;
          first_p_r <= cur_p;
        end else begin
          if (cur_t < prev_t_r) begin
            bad_r <= 1'b1;
          end
          if (!found_r && prev_t_r <= e_r && e_r < cur_t) begin
            found_r <= 1'b1;
            ta_r    <= prev_t_r;
            pa_r    <= prev_p_r;
            tb_r    <= cur_t;
            pb_r    <= cur_p;
          end
        end
        prev_t_r <= cur_t;
        prev_p_r <= cur_p;
        idx_r    <= idx_r + 1'b1;
      end
      ppsg_pkg::S_CSEL: begin
        if (bad_r) begin
          target_r <= '0;
        end else if (e_r <= first_t_r) begin
          target_r <= first_p_r;
        end else if (e_r >= prev_t_r) begin
          target_r <= prev_p_r;
        end
      end
      ppsg_pkg::S_CMUL: begin
        dneg_r <= dp[16];
        den_r  <= tb_r - ta_r;
      end
      ppsg_pkg::S_DIVI: begin
        rem_r <= prod_r[47:16];
        quo_r <= prod_r[15:0];
        cnt_r <= '0;
      end
      ppsg_pkg::S_DIV: begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[14:0], 1'b1};
        end else begin
          rem_r <= shifted[31:0];
          quo_r <= {quo_r[14:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
      end
      ppsg_pkg::S_CFIN: begin
        target_r <= cust_sum[15:0];
      end
      default: ;
    endcase
  end

  `PPSG_ASSERT_NEXT(a_busy_after_accept, in_xfer, !in_tready)
  `PPSG_ASSERT_NEXT(a_start_clears_done, in_xfer && in_cmd == ppsg_pkg::CMD_START, !done_r)
  `PPSG_ASSERT_NOW(a_div_nonzero, state_r == ppsg_pkg::S_DIV, den_r != 32'd0 && found_r)
  `PPSG_ASSERT_NOW(a_idle_only_ready, in_tready, state_r == ppsg_pkg::S_IDLE)

endmodule

// ===== src/ppsg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant table of sin over one quarter cycle, unsigned Q0.15, registered read.
// ----------------------------------------------------------------------------
module ppsg_sine_rom #(
  parameter int SINE_TABLE_BITS = ppsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic [SINE_TABLE_BITS:0] addr,
  output logic [14:0]              data
);

  localparam int Depth = (1 << SINE_TABLE_BITS) + 1;

  typedef logic [14:0] rom_t [0:Depth-1];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int j = 0; j < Depth; j++) begin
      rom[j] = ppsg_pkg::rom_entry(j, SINE_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [14:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= Rom[addr];
  end

  assign data = data_r;

endmodule
